// File: sv/lru_tile_tag_cache_assert.svh
// Assertion helpers shared by the tag cache modules.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef LRU_TILE_TAG_CACHE_ASSERT_SVH
`define LRU_TILE_TAG_CACHE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tag cache assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tag cache assertion failed");

`endif

// File: sv/ltc_pkg.sv
`default_nettype none

package ltc_pkg;

  localparam int unsigned SlotCountDef = 16;
  localparam int unsigned ModeW        = 2;
  localparam int unsigned ZoomW        = 5;
  localparam int unsigned CoordW       = 24;
  localparam int unsigned StampW       = 32;
  localparam int unsigned SlotOutW     = 4;

  typedef enum logic [ModeW-1:0] {
    ModeLookup = 2'd0,
    ModeInsert = 2'd1,
    ModeClear  = 2'd2
  } mode_e;

  // Running search record handed from cell to cell. Slot indices travel
  // beside it because their width follows the slot count.
  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [ZoomW-1:0]  zoom;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              found;
    logic              inv_found;
    logic              best_valid;
    logic [StampW-1:0] best_stamp;
  } scan_t;

  // Write-back broadcast to every cell; the target slot index travels beside it.
  typedef struct packed {
    logic              clear;
    logic              wr_stamp;
    logic              wr_key;
    logic [StampW-1:0] stamp;
    logic [ZoomW-1:0]  zoom;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } upd_t;

endpackage

`default_nettype wire

// File: sv/ltc_if.sv
`default_nettype none

interface ltc_req_if;
  import ltc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [ZoomW-1:0]  tile_zoom;
  logic [CoordW-1:0] tile_x;
  logic [CoordW-1:0] tile_y;

  modport source (output valid, output mode, output tile_zoom, output tile_x,
                  output tile_y, input ready);
  modport sink (input valid, input mode, input tile_zoom, input tile_x,
                input tile_y, output ready);
endinterface

interface ltc_rsp_if;
  import ltc_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic [SlotOutW-1:0] slot_index;
  logic                evicted_valid;

  modport source (output valid, output hit, output slot_index, output evicted_valid,
                  input ready);
  modport sink (input valid, input hit, input slot_index, input evicted_valid,
                output ready);
endinterface

`default_nettype wire

// File: sv/ltc_cell.sv
`default_nettype none

module ltc_cell #(
  parameter int unsigned SlotCount = ltc_pkg::SlotCountDef,
  parameter int unsigned CellIdx   = 0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         go_i,
  input  wire ltc_pkg::scan_t               rec_i,
  input  wire logic [$clog2(SlotCount)-1:0] midx_i,
  input  wire logic [$clog2(SlotCount)-1:0] iidx_i,
  input  wire logic [$clog2(SlotCount)-1:0] bidx_i,
  output logic                              go_o,
  output ltc_pkg::scan_t                    rec_o,
  output logic [$clog2(SlotCount)-1:0]      midx_o,
  output logic [$clog2(SlotCount)-1:0]      iidx_o,
  output logic [$clog2(SlotCount)-1:0]      bidx_o,
  input  wire ltc_pkg::upd_t                upd_i,
  input  wire logic [$clog2(SlotCount)-1:0] upd_idx_i
);
  import ltc_pkg::*;

  localparam int unsigned IdxW = $clog2(SlotCount);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic              valid_q;
  logic [StampW-1:0] stamp_q;
  logic [ZoomW-1:0]  zoom_q;
  logic [CoordW-1:0] col_q;
  logic [CoordW-1:0] row_q;

  logic              go_q;
  scan_t             rec_q, rec_d;
  logic [IdxW-1:0]   midx_q, midx_d, iidx_q, iidx_d, bidx_q, bidx_d;
  logic              key_hit;
  logic              upd_here;

  assign key_hit  = valid_q && (zoom_q == rec_i.zoom) && (col_q == rec_i.col)
                    && (row_q == rec_i.row);
  assign upd_here = (upd_idx_i == MyIdx);

  always_comb begin
    rec_d  = rec_i;
    midx_d = midx_i;
    iidx_d = iidx_i;
    bidx_d = bidx_i;
    if (!rec_i.found && key_hit) begin
      rec_d.found = 1'b1;
      midx_d      = MyIdx;
    end
    // The free-slot scan starts at slot 1.
    if ((CellIdx != 0) && !rec_i.inv_found && !valid_q) begin
      rec_d.inv_found = 1'b1;
      iidx_d          = MyIdx;
    end
    // Slot 0 seeds the oldest-stamp search; later cells win only on a strictly
    // smaller stamp, so ties stay with the lower index.
    if ((CellIdx == 0) || (valid_q && (stamp_q < rec_i.best_stamp))) begin
      rec_d.best_stamp = stamp_q;
      rec_d.best_valid = valid_q;
      bidx_d           = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q    <= 1'b0;
      valid_q <= 1'b0;
      stamp_q <= '0;
    end else begin
      go_q <= go_i;
      if (upd_i.clear) begin
        valid_q <= 1'b0;
        stamp_q <= '0;
      end else if (upd_here && upd_i.wr_stamp) begin
        stamp_q <= upd_i.stamp;
        if (upd_i.wr_key) begin
          valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q  <= rec_d;
    midx_q <= midx_d;
    iidx_q <= iidx_d;
    bidx_q <= bidx_d;
    if (!upd_i.clear && upd_here && upd_i.wr_stamp && upd_i.wr_key) begin
      zoom_q <= upd_i.zoom;
      col_q  <= upd_i.col;
      row_q  <= upd_i.row;
    end
  end

  assign go_o   = go_q;
  assign rec_o  = rec_q;
  assign midx_o = midx_q;
  assign iidx_o = iidx_q;
  assign bidx_o = bidx_q;

endmodule

`default_nettype wire

// File: sv/lru_tile_tag_cache.sv
// Tile tag cache with least-recently-used replacement.
// Requests arrive on req_i (mode, tile_zoom, tile_x, tile_y); each accepted
// item gives exactly one result on rsp_o (hit, slot_index, evicted_valid).
// Mode 0 looks a key up, mode 1 inserts or refreshes it, mode 2 clears all
// slots, mode 3 does nothing and returns zeros.
// An item walks through a row of SlotCount cells, one cell per cycle, each
// cell holding one slot and updating the running match, free-slot and
// oldest-stamp record. The write-back is broadcast when the record leaves the
// last cell. The result then enters the output register, and req_i.ready
// rises in the cycle that the result becomes valid there, so the block takes
// no new item before the last one has left the row; the pace is set by the
// length of the cell row.
// One item is in the row at a time; req_i.ready is low while it walks.
// A stalled receiver does not stop the row: a finished result waits in the
// output register, a second one in a skid register, and only while that
// skid register is full is req_i.ready held low.
// Reset invalidates every slot, zeroes all stamps and the tick, and empties
// the output side. No clearing pass is needed.
`default_nettype none

module lru_tile_tag_cache #(
  parameter int unsigned SlotCount = ltc_pkg::SlotCountDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ltc_req_if.sink    req_i,
  ltc_rsp_if.source  rsp_o
);
  import ltc_pkg::*;
  `include "lru_tile_tag_cache_assert.svh"

  localparam int unsigned IdxW = $clog2(SlotCount);

  logic               busy_q;
  logic               accept;
  logic               take;
  logic               done;
  logic [StampW-1:0]  tick_q;
  logic [StampW-1:0]  tick_inc;

  logic               go0_q;
  scan_t              rec0_q;
  logic [SlotCount:0] chain_go;
  scan_t              chain_rec  [SlotCount+1];
  logic [IdxW-1:0]    chain_midx [SlotCount+1];
  logic [IdxW-1:0]    chain_iidx [SlotCount+1];
  logic [IdxW-1:0]    chain_bidx [SlotCount+1];

  scan_t              last;
  upd_t               upd;
  logic [IdxW-1:0]    upd_idx;
  logic               res_hit;
  logic [IdxW-1:0]    res_idx;
  logic               res_evict;
  logic [IdxW+3:0]    res_idx_ext;

  logic                out_valid_q, skid_valid_q;
  logic                out_hit_q, skid_hit_q;
  logic [SlotOutW-1:0] out_idx_q, skid_idx_q;
  logic                out_evict_q, skid_evict_q;

  assign req_i.ready = !busy_q && !skid_valid_q;
  assign accept      = req_i.valid && req_i.ready;
  assign take        = out_valid_q && rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go0_q <= 1'b0;
    end else begin
      go0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rec0_q.mode       <= req_i.mode;
      rec0_q.zoom       <= req_i.tile_zoom;
      rec0_q.col        <= req_i.tile_x;
      rec0_q.row        <= req_i.tile_y;
      rec0_q.found      <= 1'b0;
      rec0_q.inv_found  <= 1'b0;
      rec0_q.best_valid <= 1'b0;
      rec0_q.best_stamp <= '0;
    end
  end

  assign chain_go[0]   = go0_q;
  assign chain_rec[0]  = rec0_q;
  assign chain_midx[0] = '0;
  assign chain_iidx[0] = '0;
  assign chain_bidx[0] = '0;

  for (genvar gi = 0; gi < SlotCount; gi++) begin : g_cell
    ltc_cell #(
      .SlotCount (SlotCount),
      .CellIdx   (gi)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .go_i      (chain_go[gi]),
      .rec_i     (chain_rec[gi]),
      .midx_i    (chain_midx[gi]),
      .iidx_i    (chain_iidx[gi]),
      .bidx_i    (chain_bidx[gi]),
      .go_o      (chain_go[gi+1]),
      .rec_o     (chain_rec[gi+1]),
      .midx_o    (chain_midx[gi+1]),
      .iidx_o    (chain_iidx[gi+1]),
      .bidx_o    (chain_bidx[gi+1]),
      .upd_i     (upd),
      .upd_idx_i (upd_idx)
    );
  end

  assign done     = chain_go[SlotCount];
  assign last     = chain_rec[SlotCount];
  assign tick_inc = tick_q + StampW'(1);

  always_comb begin
    upd.clear    = 1'b0;
    upd.wr_stamp = 1'b0;
    upd.wr_key   = 1'b0;
    upd.stamp    = tick_inc;
    upd.zoom     = last.zoom;
    upd.col      = last.col;
    upd.row      = last.row;
    upd_idx      = chain_midx[SlotCount];
    res_hit      = 1'b0;
    res_idx      = '0;
    res_evict    = 1'b0;
    if (done) begin
      case (last.mode)
        ModeLookup: begin
          if (last.found) begin
            upd.wr_stamp = 1'b1;
            res_hit      = 1'b1;
            res_idx      = chain_midx[SlotCount];
          end
        end
        ModeInsert: begin
          upd.wr_stamp = 1'b1;
          upd.wr_key   = 1'b1;
          res_hit      = last.found;
          if (last.found) begin
            upd_idx = chain_midx[SlotCount];
          end else if (last.inv_found) begin
            upd_idx = chain_iidx[SlotCount];
          end else begin
            upd_idx   = chain_bidx[SlotCount];
            res_evict = last.best_valid;
          end
          res_idx = upd_idx;
        end
        ModeClear: begin
          upd.clear = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_idx_ext = {4'b0000, res_idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      tick_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (upd.clear) begin
        tick_q <= '0;
      end else if (upd.wr_stamp) begin
        tick_q <= tick_inc;
      end
      if (done) begin
        if (!out_valid_q || take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (take) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      if (!out_valid_q || take) begin
        out_hit_q   <= res_hit;
        out_idx_q   <= res_idx_ext[SlotOutW-1:0];
        out_evict_q <= res_evict;
      end else begin
        skid_hit_q   <= res_hit;
        skid_idx_q   <= res_idx_ext[SlotOutW-1:0];
        skid_evict_q <= res_evict;
      end
    end else if (take && skid_valid_q) begin
      out_hit_q   <= skid_hit_q;
      out_idx_q   <= skid_idx_q;
      out_evict_q <= skid_evict_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.hit           = out_hit_q;
  assign rsp_o.slot_index    = out_idx_q;
  assign rsp_o.evicted_valid = out_evict_q;

  // Only one search record may be in the cell row at any time.
  `LTC_ASSERT_IMP(a_one_record, 1'b1, $onehot0(chain_go))
  // The skid register is only used behind a full output register.
  `LTC_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q)
  `LTC_ASSERT_NXT(a_busy_after_accept, accept, busy_q)
  `LTC_ASSERT_NXT(a_clear_zeroes_tick, upd.clear, tick_q == '0)

endmodule

`default_nettype wire

// File: tb/lru_tile_tag_cache_tb.sv
`timescale 1ns / 100ps

module lru_tile_tag_cache_tb;
  import ltc_pkg::*;

  localparam int unsigned Slots       = SlotCountDef;
  localparam int unsigned RandomItems = 1226;
  localparam int unsigned PoolSize    = 24;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned DrainCycles = 60;

  // Mode 3 has no member in the package enum; the block must ignore it.
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  typedef enum logic [1:0] {
    PaceFull,
    PaceSendIdle,
    PaceRecvStall,
    PaceBoth
  } pace_e;

  typedef struct packed {
    logic [ZoomW-1:0]  zoom;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } tile_key_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    tile_key_t        key;
  } tile_req_t;

  typedef struct packed {
    logic                hit;
    logic [SlotOutW-1:0] slot;
    logic                evicted;
  } tile_rsp_t;

  typedef struct packed {
    pace_e     pace;
    tile_req_t req;
  } tile_item_t;

  logic clk_i;
  logic rst_ni;

  ltc_req_if req_if ();
  ltc_rsp_if rsp_if ();

  lru_tile_tag_cache u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the tag store.
  logic              shadow_valid [Slots];
  tile_key_t         shadow_key   [Slots];
  logic [StampW-1:0] shadow_stamp [Slots];
  logic [StampW-1:0] shadow_tick;

  tile_item_t  tile_req_q [$];
  tile_rsp_t   slot_rsp_q [$];
  tile_key_t   key_pool   [PoolSize];
  pace_e       cur_pace;
  bit          req_taken;
  int unsigned req_accepted;
  int unsigned quiet_cycles;
  int unsigned mismatch_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic tile_rsp_t lru_access(tile_req_t req);
    tile_rsp_t         rsp;
    int                slot;
    logic [StampW-1:0] oldest;
    bit                free_found;
    rsp  = '0;
    slot = -1;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_key[i] == req.key) slot = i;
    end
    case (req.mode)
      ModeLookup: begin
        if (slot >= 0) begin
          shadow_tick++;
          shadow_stamp[slot] = shadow_tick;
          rsp.hit  = 1'b1;
          rsp.slot = SlotOutW'(slot);
        end
      end
      ModeInsert: begin
        if (slot >= 0) begin
          rsp.hit = 1'b1;
        end else begin
          // The first free slot from index 1 wins; otherwise the oldest stamp,
          // with slot 0 in the running and ties kept by the lower index.
          slot       = 0;
          oldest     = shadow_stamp[0];
          free_found = 1'b0;
          for (int i = 1; i < Slots; i++) begin
            if (!free_found) begin
              if (!shadow_valid[i]) begin
                slot       = i;
                free_found = 1'b1;
              end else if (shadow_stamp[i] < oldest) begin
                slot   = i;
                oldest = shadow_stamp[i];
              end
            end
          end
          rsp.evicted = shadow_valid[slot];
        end
        shadow_key[slot]   = req.key;
        shadow_tick++;
        shadow_stamp[slot] = shadow_tick;
        shadow_valid[slot] = 1'b1;
        rsp.slot           = SlotOutW'(slot);
      end
      ModeClear: begin
        for (int i = 0; i < Slots; i++) begin
          shadow_valid[i] = 1'b0;
          shadow_stamp[i] = '0;
        end
        shadow_tick = '0;
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  function automatic tile_key_t rand_key();
    tile_key_t key;
    key.zoom = ($urandom_range(0, 7) == 0) ? ZoomW'($urandom_range(25, 31))
                                           : ZoomW'($urandom_range(0, 24));
    key.col  = CoordW'($urandom());
    key.row  = CoordW'($urandom());
    return key;
  endfunction

  function automatic void add_req(logic [ModeW-1:0] mode, tile_key_t key, pace_e pace);
    tile_item_t item;
    item.pace     = pace;
    item.req.mode = mode;
    item.req.key  = key;
    tile_req_q.push_back(item);
  endfunction

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic check_field(input string field_name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field_name, want, got);
    end
  endtask

  // Driver: inputs change on the falling edge only.
  always @(negedge clk_i) begin : drive_req
    tile_item_t item;
    if (rst_ni) begin
      if (!req_if.valid || req_taken) begin
        req_taken = 1'b0;
        if (tile_req_q.size() != 0 &&
            !chance(tile_req_q[0].pace == PaceSendIdle ? 83 :
                    tile_req_q[0].pace == PaceBoth ? 32 : 0)) begin
          item              = tile_req_q.pop_front();
          cur_pace          = item.pace;
          req_if.valid     <= 1'b1;
          req_if.mode      <= item.req.mode;
          req_if.tile_zoom <= item.req.key.zoom;
          req_if.tile_x    <= item.req.key.col;
          req_if.tile_y    <= item.req.key.row;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      rsp_if.ready <= !chance(cur_pace == PaceRecvStall ? 83 : cur_pace == PaceBoth ? 32 : 0);
    end
  end

  always @(posedge clk_i) begin : observe
    tile_req_t req;
    tile_rsp_t got;
    tile_rsp_t want;
    if (rst_ni) begin
      quiet_cycles++;
      if (req_if.valid && req_if.ready) begin
        req.mode     = req_if.mode;
        req.key.zoom = req_if.tile_zoom;
        req.key.col  = req_if.tile_x;
        req.key.row  = req_if.tile_y;
        slot_rsp_q.push_back(lru_access(req));
        req_taken    = 1'b1;
        req_accepted++;
        quiet_cycles = 0;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        quiet_cycles = 0;
        got.hit      = rsp_if.hit;
        got.slot     = rsp_if.slot_index;
        got.evicted  = rsp_if.evicted_valid;
        if (slot_rsp_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected item, expected none, got hit=%0d slot=%0d evicted=%0d",
                   $time, got.hit, got.slot, got.evicted);
        end else begin
          want = slot_rsp_q.pop_front();
          check_field("hit", 8'(want.hit), 8'(got.hit));
          check_field("slot_index", 8'(want.slot), 8'(got.slot));
          check_field("evicted_valid", 8'(want.evicted), 8'(got.evicted));
        end
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    tile_key_t   key_a;
    tile_key_t   key_b;
    tile_key_t   key;
    int unsigned total_items;
    int unsigned pick;
    pace_e       pace;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.mode      = ModeLookup;
    req_if.tile_zoom = '0;
    req_if.tile_x    = '0;
    req_if.tile_y    = '0;
    rsp_if.ready     = 1'b0;
    cur_pace         = PaceFull;
    req_taken        = 1'b0;
    req_accepted     = 0;
    quiet_cycles     = 0;
    mismatch_count   = 0;
    shadow_tick      = '0;
    for (int i = 0; i < Slots; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_stamp[i] = '0;
    end

    key_a = '0;
    key_b = '1;
    key_pool[0] = key_a;
    key_pool[1] = key_b;
    for (int i = 2; i < PoolSize; i++) key_pool[i] = rand_key();

    // Directed: miss on an empty store, extreme keys, hit and refresh, the
    // ignored mode, filling every slot so that slot 0 is taken last, then a
    // true eviction, a near miss, and a clear followed by a miss.
    add_req(ModeLookup, key_a, PaceFull);
    add_req(ModeInsert, key_a, PaceFull);
    add_req(ModeInsert, key_b, PaceFull);
    add_req(ModeLookup, key_a, PaceFull);
    add_req(ModeInsert, key_b, PaceFull);
    add_req(ModeUnused, key_b, PaceFull);
    for (int i = 0; i < 13; i++) begin
      key.zoom = ZoomW'(i + 12);
      key.col  = CoordW'(i);
      key.row  = ~CoordW'(i);
      add_req(ModeInsert, key, PaceFull);
    end
    add_req(ModeInsert, '{zoom: 5'd24, col: 24'h800000, row: 24'h000001}, PaceFull);
    add_req(ModeInsert, '{zoom: 5'd7, col: 24'h123456, row: 24'hABCDEF}, PaceFull);
    add_req(ModeLookup, '{zoom: 5'd0, col: 24'h0, row: 24'h1}, PaceFull);
    add_req(ModeClear, key_b, PaceFull);
    add_req(ModeLookup, key_a, PaceFull);

    // Random: mostly lookups and inserts over a small key pool, larger than
    // the store, so that hits, refreshes and evictions all stay frequent.
    for (int i = 0; i < RandomItems; i++) begin
      pace = pace_e'(i * 4 / RandomItems);
      pick = $urandom_range(0, 99);
      key  = key_pool[$urandom_range(0, PoolSize - 1)];
      if (pick < 44) begin
        add_req(ModeLookup, key, pace);
      end else if (pick < 80) begin
        add_req(ModeInsert, key, pace);
      end else if (pick < 88) begin
        case ($urandom_range(0, 2))
          0:       key.zoom[$urandom_range(0, ZoomW - 1)] ^= 1'b1;
          1:       key.col[$urandom_range(0, CoordW - 1)] ^= 1'b1;
          default: key.row[$urandom_range(0, CoordW - 1)] ^= 1'b1;
        endcase
        add_req(chance(50) ? ModeLookup : ModeInsert, key, pace);
      end else if (pick < 93) begin
        add_req(ModeInsert, rand_key(), pace);
      end else if (pick < 96) begin
        add_req(ModeUnused, rand_key(), pace);
      end else if (pick < 98) begin
        add_req(ModeLookup, rand_key(), pace);
      end else begin
        add_req(ModeClear, rand_key(), pace);
        key_pool[$urandom_range(2, PoolSize - 1)] = rand_key();
      end
    end
    total_items = tile_req_q.size();

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (req_accepted == total_items && slot_rsp_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
